// ===== sv/array_insert_delete_search_assert.svh =====
// Assertion macros for the packed array block.
// Used by array_insert_delete_search; expects clk and arst_n in scope.
`ifndef ARRAY_INSERT_DELETE_SEARCH_ASSERT_SVH
`define ARRAY_INSERT_DELETE_SEARCH_ASSERT_SVH

// same-cycle implication
`define AIDS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AIDS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/aids_pkg.sv =====
// Shared sizes and codes for the packed array block.
// No dependencies.
package aids_pkg;
	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int FUNC_W     = 3;
	localparam int POS_W      = 5;
	localparam int STAT_W     = 2;

	localparam logic [FUNC_W-1:0] FN_READ   = 3'd0;
	localparam logic [FUNC_W-1:0] FN_INSERT = 3'd1;
	localparam logic [FUNC_W-1:0] FN_DELETE = 3'd2;
	localparam logic [FUNC_W-1:0] FN_SEARCH = 3'd3;
	localparam logic [FUNC_W-1:0] FN_SORT   = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] ST_BADPOS   = 2'd2;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;
endpackage

// ===== sv/aids_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module aids_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== sv/array_insert_delete_search.sv =====
// Packed array of signed words with read, insert, delete, search and sorted
// insert. One request at a time; every request yields one response word.
// Depends on aids_pkg, aids_ram and array_insert_delete_search_assert.svh.
//
// The single RAM read port walks one entry per cycle for scans and shifts; requests
// that fail their checks go straight to the done state. A finished response sits
// in an output register, so the next request is taken while it waits to be
// collected. No clearing pass.
module array_insert_delete_search (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic [aids_pkg::FUNC_W-1:0]         func,
	input  logic [aids_pkg::POS_W-1:0]          position,
	input  logic signed [aids_pkg::DATA_WIDTH-1:0] value,
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic [aids_pkg::STAT_W-1:0]         status,
	output logic [aids_pkg::IDX_W-1:0]          found_index,
	output logic signed [aids_pkg::DATA_WIDTH-1:0] read_data,
	output logic [aids_pkg::CNT_W-1:0]          count
);
	import aids_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_RD_WAIT, S_SCAN, S_SHIFT_UP, S_SHIFT_DN, S_WR_VAL, S_DONE
	} state_t;

	state_t                  state_q;
	logic [FUNC_W-1:0]       func_q;
	logic signed [DATA_WIDTH-1:0] value_q;
	logic [CNT_W-1:0]        count_q;
	logic [IDX_W-1:0]        ptr_q;
	logic [IDX_W-1:0]        tgt_q;
	logic [IDX_W-1:0]        slot_q;
	logic [STAT_W-1:0]       res_status_q;
	logic [IDX_W-1:0]        res_index_q;
	logic [DATA_WIDTH-1:0]   res_data_q;
	logic                    rsp_valid_q;
	logic [STAT_W-1:0]       status_q;
	logic [IDX_W-1:0]        index_q;
	logic [DATA_WIDTH-1:0]   data_q;
	logic [CNT_W-1:0]        count_out_q;

	logic                    accept;
	logic [IDX_W-1:0]        pos_idx;
	logic [IDX_W-1:0]        cnt_last;
	logic [CNT_W-1:0]        ptr_inc;
	logic [CNT_W-1:0]        count_inc;
	logic                    scan_last;
	logic                    cmp_eq;
	logic                    cmp_le;
	logic [IDX_W-1:0]        slot_nx;
	logic [IDX_W-1:0]        raddr;
	logic                    we;
	logic [IDX_W-1:0]        waddr;
	logic [DATA_WIDTH-1:0]   wdata;
	logic [DATA_WIDTH-1:0]   rd_data;
	logic                    pos_in_range;
	logic                    pos_ins_ok;
	state_t                  acc_state;
	logic [STAT_W-1:0]       acc_status;
	logic [IDX_W-1:0]        acc_tgt;
	logic                    acc_shrink;
	logic                    rsp_load;

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;

	assign pos_idx   = IDX_W'(position - POS_W'(1));
	assign cnt_last  = IDX_W'(count_q - CNT_W'(1));
	assign ptr_inc   = CNT_W'(ptr_q) + CNT_W'(1);
	assign count_inc = count_q + CNT_W'(1);
	assign scan_last = (ptr_inc >= count_q);

	assign pos_in_range = (position != '0) && (CNT_W'(position) <= count_q);
	assign pos_ins_ok   = (position != '0)
		&& ((CNT_W + 1)'(position) <= (CNT_W + 1)'(count_q) + (CNT_W + 1)'(1));

	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);

	// shared compare unit on the word coming out of the RAM
	assign cmp_eq  = (rd_data == value_q);
	assign cmp_le  = ($signed(rd_data) <= value_q);
	assign slot_nx = cmp_le ? IDX_W'(ptr_inc) : slot_q;

	// decode of a new request
	always_comb begin
		acc_state  = S_DONE;
		acc_status = ST_OK;
		acc_tgt    = pos_idx;
		acc_shrink = 1'b0;
		unique case (func)
			FN_READ: begin
				if (pos_in_range) begin
					acc_state = S_RD_WAIT;
				end else begin
					acc_status = ST_BADPOS;
				end
			end
			FN_INSERT: begin
				if (count_q >= CNT_W'(DEPTH)) begin
					acc_status = ST_FULL;
				end else if (!pos_ins_ok) begin
					acc_status = ST_BADPOS;
				end else if (count_q >= CNT_W'(position)) begin
					acc_state = S_SHIFT_UP;
				end else begin
					acc_state = S_WR_VAL;
				end
			end
			FN_DELETE: begin
				if (!pos_in_range) begin
					acc_status = ST_BADPOS;
				end else if (CNT_W'(position) < count_q) begin
					acc_state = S_SHIFT_DN;
				end else begin
					acc_shrink = 1'b1;
				end
			end
			FN_SEARCH: begin
				if (count_q == '0) begin
					acc_status = ST_NOTFOUND;
				end else begin
					acc_state = S_SCAN;
				end
			end
			FN_SORT: begin
				acc_tgt = '0;
				if (count_q >= CNT_W'(DEPTH)) begin
					acc_status = ST_FULL;
				end else if (count_q == '0) begin
					acc_state = S_WR_VAL;
				end else begin
					acc_state = S_SCAN;
				end
			end
			default: acc_status = ST_BADPOS;
		endcase
	end

	// read address; the RAM output always holds the word at ptr_q
	always_comb begin
		unique case (state_q)
			S_IDLE: begin
				unique case (func)
					FN_READ:   raddr = pos_idx;
					FN_INSERT: raddr = cnt_last;
					FN_DELETE: raddr = IDX_W'(position);
					default:   raddr = '0;
				endcase
			end
			S_SCAN:     raddr = scan_last ? ptr_q : IDX_W'(ptr_inc);
			S_SHIFT_UP: raddr = ptr_q - IDX_W'(1);
			S_SHIFT_DN: raddr = IDX_W'(ptr_inc);
			default:    raddr = ptr_q;
		endcase
	end

	always_comb begin
		we    = (state_q == S_SHIFT_UP) || (state_q == S_SHIFT_DN) || (state_q == S_WR_VAL);
		wdata = (state_q == S_WR_VAL) ? value_q : rd_data;
		unique case (state_q)
			S_SHIFT_UP: waddr = ptr_q + IDX_W'(1);
			S_SHIFT_DN: waddr = ptr_q - IDX_W'(1);
			default:    waddr = tgt_q;
		endcase
	end

	aids_ram #(
		.DEPTH(DEPTH),
		.WIDTH(DATA_WIDTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			ptr_q <= raddr;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						func_q       <= func;
						value_q      <= value;
						res_status_q <= acc_status;
						res_index_q  <= '0;
						res_data_q   <= '0;
						slot_q       <= '0;
						tgt_q        <= acc_tgt;
						state_q      <= acc_state;
						if (acc_shrink) begin
							count_q <= count_q - CNT_W'(1);
						end
					end
				end
				S_RD_WAIT: begin
					res_data_q  <= rd_data;
					res_index_q <= tgt_q;
					state_q     <= S_DONE;
				end
				S_SCAN: begin
					if (func_q == FN_SEARCH) begin
						if (cmp_eq) begin
							res_index_q <= ptr_q;
							state_q     <= S_DONE;
						end else if (scan_last) begin
							res_status_q <= ST_NOTFOUND;
							state_q      <= S_DONE;
						end
					end else begin
						slot_q <= slot_nx;
						if (scan_last) begin
							tgt_q <= slot_nx;
							// scan_last leaves ptr_q on the last entry for the shift
							if (CNT_W'(slot_nx) < count_q) begin
								state_q <= S_SHIFT_UP;
							end else begin
								state_q <= S_WR_VAL;
							end
						end
					end
				end
				S_SHIFT_UP: begin
					if (ptr_q == tgt_q) begin
						state_q <= S_WR_VAL;
					end
				end
				S_SHIFT_DN: begin
					if (scan_last) begin
						count_q <= count_q - CNT_W'(1);
						state_q <= S_DONE;
					end
				end
				S_WR_VAL: begin
					count_q     <= count_inc;
					res_index_q <= tgt_q;
					state_q     <= S_DONE;
				end
				S_DONE: begin
					if (rsp_load) begin
						status_q    <= res_status_q;
						index_q     <= res_index_q;
						data_q      <= res_data_q;
						count_out_q <= count_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign found_index = index_q;
	assign read_data   = data_q;
	assign count       = count_out_q;

`include "array_insert_delete_search_assert.svh"

	`AIDS_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(DEPTH), "count beyond depth")
	`AIDS_ASSERT_NOW(a_write_in_use, we, CNT_W'(waddr) <= count_q, "write past packed entries")
	`AIDS_ASSERT_NEXT(a_wr_grows, state_q == S_WR_VAL, count_q == $past(count_inc), "no growth")
	`AIDS_ASSERT_NOW(a_up_room, state_q == S_SHIFT_UP, count_q < CNT_W'(DEPTH), "shift when full")

endmodule

// ===== dv/tb_array_insert_delete_search.sv =====
`timescale 1ns / 1ps
// Self-checking bench for array_insert_delete_search: directed and random requests
// checked against a behavioral shadow of the packed array, under several idle mixes.
// Depends on aids_pkg and the block's RTL.
module tb_array_insert_delete_search;
	import aids_pkg::*;

	localparam logic [FUNC_W-1:0] FN_BAD_LO = 3'd5;
	localparam logic [FUNC_W-1:0] FN_BAD_HI = 3'd7;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int DRAIN_CYCLES = 80;
	localparam int RANDOM_WORDS = 406;
	localparam logic signed [DATA_WIDTH-1:0] WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
	localparam logic signed [DATA_WIDTH-1:0] WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

	typedef struct packed {
		logic [STAT_W-1:0]            st;
		logic [IDX_W-1:0]             idx;
		logic signed [DATA_WIDTH-1:0] data;
		logic [CNT_W-1:0]             cnt;
	} array_rsp_t;

	logic                         clk;
	logic                         arst_n;
	logic                         req_valid;
	logic                         req_stall;
	logic [FUNC_W-1:0]            func;
	logic [POS_W-1:0]             position;
	logic signed [DATA_WIDTH-1:0] value;
	logic                         rsp_valid;
	logic                         rsp_stall;
	logic [STAT_W-1:0]            status;
	logic [IDX_W-1:0]             found_index;
	logic signed [DATA_WIDTH-1:0] read_data;
	logic [CNT_W-1:0]             count;

	array_rsp_t                   pending_rsp_q[$];
	logic signed [DATA_WIDTH-1:0] shadow_words[DEPTH];
	int                           shadow_count;
	int                           send_idle_pct;
	int                           stall_pct;
	int                           mismatches;
	int                           words_checked;
	int                           cycles;
	int                           func_hits[8];
	int                           status_hits[4];
	bit                           growing;

	array_insert_delete_search u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.func        (func),
		.position    (position),
		.value       (value),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.found_index (found_index),
		.read_data   (read_data),
		.count       (count)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// shift up from idx and place w
	function automatic void shadow_put(int idx, logic signed [DATA_WIDTH-1:0] w);
		for (int i = shadow_count; i > idx; i--)
			shadow_words[i] = shadow_words[i-1];
		shadow_words[idx] = w;
		shadow_count++;
	endfunction

	function automatic array_rsp_t apply_request(logic [FUNC_W-1:0] f, logic [POS_W-1:0] p,
			logic signed [DATA_WIDTH-1:0] v);
		array_rsp_t r;
		int         slot;
		r = '0;
		r.st = ST_OK;
		case (f)
		FN_READ: begin
			if (p >= 1 && p <= shadow_count) begin
				r.idx  = IDX_W'(p - 1);
				r.data = shadow_words[p-1];
			end else begin
				r.st = ST_BADPOS;
			end
		end
		FN_INSERT: begin
			if (shadow_count >= DEPTH) begin
				r.st = ST_FULL;
			end else if (p < 1 || p > shadow_count + 1) begin
				r.st = ST_BADPOS;
			end else begin
				r.idx = IDX_W'(p - 1);
				shadow_put(p - 1, v);
			end
		end
		FN_DELETE: begin
			if (p >= 1 && p <= shadow_count) begin
				for (int i = p - 1; i + 1 < shadow_count; i++)
					shadow_words[i] = shadow_words[i+1];
				shadow_count--;
			end else begin
				r.st = ST_BADPOS;
			end
		end
		FN_SEARCH: begin
			r.st = ST_NOTFOUND;
			for (int i = 0; i < shadow_count; i++) begin
				if (r.st == ST_NOTFOUND && shadow_words[i] == v) begin
					r.st  = ST_OK;
					r.idx = IDX_W'(i);
				end
			end
		end
		FN_SORT: begin
			if (shadow_count >= DEPTH) begin
				r.st = ST_FULL;
			end else begin
				slot = 0;
				for (int i = 0; i < shadow_count; i++)
					if (shadow_words[i] <= v)
						slot = i + 1;
				r.idx = IDX_W'(slot);
				shadow_put(slot, v);
			end
		end
		default: begin
			r.st = ST_BADPOS;
		end
		endcase
		r.cnt = CNT_W'(shadow_count);
		func_hits[f]++;
		status_hits[r.st]++;
		return r;
	endfunction

	task automatic send_req(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
			input logic signed [DATA_WIDTH-1:0] v);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		func      <= f;
		position  <= p;
		value     <= v;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		pending_rsp_q.push_back(apply_request(f, p, v));
	endtask

	task automatic set_idling(input int snd_pct, input int rcv_pct);
		send_idle_pct = snd_pct;
		stall_pct     = rcv_pct;
	endtask

	task automatic test_empty_array();
		send_req(FN_READ, 5'd1, '0);
		send_req(FN_DELETE, 5'd1, '0);
		send_req(FN_SEARCH, 5'd0, '0);
	endtask

	task automatic test_sorted_insert();
		send_req(FN_SORT, 5'd0, '0);
		send_req(FN_SORT, 5'd16, WORD_MIN);
		send_req(FN_SORT, 5'd31, WORD_MAX);
		send_req(FN_SORT, 5'd1, '0);
	endtask

	task automatic test_positional_insert();
		send_req(FN_INSERT, 5'd0, 32'sd7);
		send_req(FN_INSERT, POS_W'(shadow_count + 2), 32'sd7);
		send_req(FN_INSERT, POS_W'(shadow_count + 1), -32'sd1);
		send_req(FN_INSERT, 5'd1, 32'h5555_5555);
		send_req(FN_INSERT, 5'd3, 32'hAAAA_AAAA);
	endtask

	task automatic test_search_read();
		send_req(FN_SEARCH, 5'd31, '0);
		send_req(FN_SEARCH, 5'd0, WORD_MAX);
		send_req(FN_SEARCH, 5'd1, 32'sd12345);
		send_req(FN_READ, 5'd1, '0);
		send_req(FN_READ, POS_W'(shadow_count), '0);
		send_req(FN_READ, POS_W'(shadow_count + 1), '0);
		send_req(FN_READ, 5'd31, '0);
	endtask

	task automatic test_delete();
		send_req(FN_DELETE, 5'd1, '0);
		send_req(FN_DELETE, POS_W'(shadow_count), '0);
		send_req(FN_DELETE, 5'd0, '0);
	endtask

	task automatic test_unknown_func();
		for (int k = FN_BAD_LO; k <= FN_BAD_HI; k++)
			send_req(FUNC_W'(k), 5'd31, -32'sd1);
	endtask

	// bursts drift the fill level between empty and full
	task automatic test_random_mix(input int n_words);
		logic [FUNC_W-1:0]            f;
		logic [POS_W-1:0]             p;
		logic signed [DATA_WIDTH-1:0] v;
		int                           r;
		for (int k = 0; k < n_words; k++) begin
			if (shadow_count == DEPTH && $urandom_range(2) == 0)
				growing = 1'b0;
			else if (shadow_count == 0 && $urandom_range(2) == 0)
				growing = 1'b1;
			else if ($urandom_range(49) == 0)
				growing = !growing;

			r = $urandom_range(99);
			if (r < 4)
				f = FUNC_W'($urandom_range(FN_BAD_HI, FN_BAD_LO));
			else if (r < 19)
				f = FN_READ;
			else if (r < 34)
				f = FN_SEARCH;
			else if (r < (growing ? 64 : 44))
				f = FN_INSERT;
			else if (r < (growing ? 90 : 54))
				f = FN_SORT;
			else
				f = FN_DELETE;

			if ($urandom_range(9) == 0)
				p = POS_W'($urandom_range(31));
			else if (f == FN_INSERT)
				p = POS_W'($urandom_range(shadow_count + 1, 1));
			else
				p = POS_W'($urandom_range(shadow_count > 0 ? shadow_count : 1, 1));

			r = $urandom_range(99);
			if (r < 30 && shadow_count > 0)
				v = shadow_words[$urandom_range(shadow_count - 1)];
			else if (r < 45)
				v = DATA_WIDTH'(int'($urandom_range(8)) - 4);
			else if (r < 55)
				v = $urandom_range(1) ? WORD_MAX : WORD_MIN;
			else
				v = $urandom;

			send_req(f, p, v);
		end
	endtask

	always @(negedge clk) begin
		rsp_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin : rsp_check
		array_rsp_t got;
		array_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			got = '{status, found_index, read_data, count};
			words_checked++;
			if (pending_rsp_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: response word with nothing pending: st=%0d idx=%0d data=%0d cnt=%0d",
						$realtime, got.st, got.idx, got.data, got.cnt);
			end else begin
				want = pending_rsp_q.pop_front();
				if (got.st !== want.st || got.idx !== want.idx ||
						got.data !== want.data || got.cnt !== want.cnt) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: exp st=%0d idx=%0d data=%0d cnt=%0d, got st=%0d idx=%0d data=%0d cnt=%0d",
							$realtime, want.st, want.idx, want.data, want.cnt,
							got.st, got.idx, got.data, got.cnt);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words still pending", cycles,
				pending_rsp_q.size());
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		func          = FN_READ;
		position      = '0;
		value         = '0;
		rsp_stall     = 1'b0;
		send_idle_pct = 0;
		stall_pct     = 0;
		mismatches    = 0;
		words_checked = 0;
		cycles        = 0;
		shadow_count  = 0;
		growing       = 1'b1;
		foreach (shadow_words[i])
			shadow_words[i] = '0;
		foreach (func_hits[i])
			func_hits[i] = 0;
		foreach (status_hits[i])
			status_hits[i] = 0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_array();
		test_sorted_insert();
		test_positional_insert();
		test_search_read();
		test_delete();
		test_unknown_func();

		set_idling(0, 0);
		test_random_mix(RANDOM_WORDS);
		set_idling(85, 0);
		test_random_mix(RANDOM_WORDS);
		set_idling(0, 85);
		test_random_mix(RANDOM_WORDS);
		set_idling(13, 13);
		test_random_mix(RANDOM_WORDS);

		@(negedge clk);
		req_valid <= 1'b0;
		while (pending_rsp_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d requests: read %0d, insert %0d, delete %0d, search %0d, sorted %0d, illegal %0d",
			func_hits.sum(), func_hits[FN_READ], func_hits[FN_INSERT], func_hits[FN_DELETE],
			func_hits[FN_SEARCH], func_hits[FN_SORT],
			func_hits[5] + func_hits[6] + func_hits[7]);
		$display("Outcomes: ok %0d, full %0d, bad position %0d, not found %0d; %0d words checked",
			status_hits[ST_OK], status_hits[ST_FULL], status_hits[ST_BADPOS],
			status_hits[ST_NOTFOUND], words_checked);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
